// ===== hw/rtl/tcf_pkg.sv =====
// shared constants, tables and helpers of the tilt complementary filter
package tcf_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_GAIN = 2'd2;

   localparam logic [15:0] COEF_A_RST    = 16'd3121;
   localparam logic [15:0] COEF_B_RST    = 16'd62415;
   localparam logic [23:0] GYRO_GAIN_RST = 24'd4871;

   // cordic datapath
   localparam int TABLE_LEN = 24;
   localparam int CORDIC_W  = 28;
   localparam int Z_W       = 26;
   localparam int ANGLE_MAX = 23040;

   localparam logic signed [Z_W-1:0] DEG180_Q = 26'sd5898240;

   // shared multiplier: signed state or sample times unsigned coefficient
   localparam int OPA_W  = 32;
   localparam int OPB_W  = 25;
   localparam int PROD_W = OPA_W + OPB_W;

   localparam logic signed [23:0] OUT_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] OUT_MIN = 24'sh800000;

   // atan(2^-i) in 1/32768 degree
   function automatic logic [20:0] atan_q(input logic [4:0] idx);
      logic [20:0] val;
      case (idx)
         5'd0:  val = 21'd1474560;
         5'd1:  val = 21'd870484;
         5'd2:  val = 21'd459940;
         5'd3:  val = 21'd233473;
         5'd4:  val = 21'd117189;
         5'd5:  val = 21'd58653;
         5'd6:  val = 21'd29333;
         5'd7:  val = 21'd14667;
         5'd8:  val = 21'd7334;
         5'd9:  val = 21'd3667;
         5'd10: val = 21'd1833;
         5'd11: val = 21'd917;
         5'd12: val = 21'd458;
         5'd13: val = 21'd229;
         5'd14: val = 21'd115;
         5'd15: val = 21'd57;
         5'd16: val = 21'd29;
         5'd17: val = 21'd14;
         5'd18: val = 21'd7;
         5'd19: val = 21'd4;
         5'd20: val = 21'd2;
         5'd21: val = 21'd1;
         default: val = 21'd0;
      endcase
      return val;
   endfunction

   // saturating sum of two output terms
   function automatic logic signed [23:0] sat_sum24(input logic signed [23:0] a,
                                                    input logic signed [23:0] b);
      logic signed [24:0] s;
      logic signed [23:0] r;
      s = {a[23], a} + {b[23], b};
      if (s > signed'({OUT_MAX[23], OUT_MAX})) begin
         r = OUT_MAX;
      end else if (s < signed'({OUT_MIN[23], OUT_MIN})) begin
         r = OUT_MIN;
      end else begin
         r = s[23:0];
      end
      return r;
   endfunction

   // state in 1/32768 degree rounded to 1/128 degree, saturated to 24 bits
   function automatic logic signed [23:0] round8_sat24(input logic signed [31:0] v);
      logic signed [32:0] b;
      logic signed [24:0] q;
      logic signed [23:0] r;
      b = {v[31], v} + 33'sd128;
      q = b[32:8];
      if (q > signed'({OUT_MAX[23], OUT_MAX})) begin
         r = OUT_MAX;
      end else if (q < signed'({OUT_MIN[23], OUT_MIN})) begin
         r = OUT_MIN;
      end else begin
         r = q[23:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/tcf_if.sv =====
// sample and result channels of the tilt complementary filter
interface tcf_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] gyro_z;

   modport source(output valid, output accel_x, output accel_y, output gyro_z,
                  input ready);
   modport sink(input valid, input accel_x, input accel_y, input gyro_z,
                output ready);
endinterface

interface tcf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_angle;
   logic signed [23:0] smoothed_angle;
   logic signed [23:0] rate_angle;
   logic signed [23:0] fused_angle;

   modport source(output valid, output accel_angle, output smoothed_angle,
                  output rate_angle, output fused_angle, input ready);
   modport sink(input valid, input accel_angle, input smoothed_angle,
                input rate_angle, input fused_angle, output ready);
endinterface

// ===== hw/rtl/tilt_complementary_filter_unit.sv =====
// tilt complementary filter: cordic atan2 tilt angle fused with filtered gyro rate
//
// One sample beat carries accelerometer X/Y and gyro Z. The tilt angle
// atan2(accel_y, accel_x) comes from a vectoring CORDIC that runs one
// rotation per cycle on a single add/shift stage, min(CORDIC_STEPS, 24)
// rotations in all. A single 32x25 multiplier then forms the four filter
// products in turn (angle rounding, four multiplies, the accumulations
// and the two state updates), and then the result register is loaded.
// The unit takes no new sample before the CORDIC iterations and the
// shared multiplier are done with the last one; it is not ready while a
// sample is in work. The result register frees the sample side once the
// previous result is taken. Angles are in 1/128 degree, filter states
// keep 8 more fraction bits, and coefficients are Q0.COEF_FRAC_BITS.
// Both filter states reset to zero.
module tilt_complementary_filter_unit #(
   parameter int CORDIC_STEPS   = 16,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   tcf_req_if.sink                        req_ch,
   tcf_rsp_if.source                      rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [tcf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tcf_pkg::*;

   localparam int N_STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam int STEP_W  = $clog2(N_STEPS);
   localparam int F       = COEF_FRAC_BITS;
   localparam int ACC_W   = 50 + F;
   localparam int RND_W   = ACC_W - F;
   localparam int ZR_W    = Z_W - 8;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CORDIC = 2'd1;
   localparam logic [1:0] ST_MUL    = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   localparam logic [2:0] MC_ANGLE   = 3'd0;
   localparam logic [2:0] MC_MUL_A   = 3'd1;
   localparam logic [2:0] MC_MUL_B   = 3'd2;
   localparam logic [2:0] MC_MUL_G   = 3'd3;
   localparam logic [2:0] MC_MUL_R   = 3'd4;
   localparam logic [2:0] MC_ACC_R   = 3'd5;
   localparam logic [2:0] MC_STORE_R = 3'd6;

   localparam logic signed [ZR_W-1:0]  ZR_MAX = ZR_W'(ANGLE_MAX);
   localparam logic signed [ZR_W-1:0]  ZR_MIN = -ZR_W'(ANGLE_MAX);
   localparam logic signed [RND_W-1:0] LP_MAX = {{(RND_W-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [RND_W-1:0] LP_MIN = {{(RND_W-31){1'b1}}, {31{1'b0}}};

   logic [1:0]                 state_ff, state_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [2:0]                 mcnt_ff, mcnt_in;
   logic [15:0]                coef_a_ff, coef_a_in;
   logic [15:0]                coef_b_ff, coef_b_in;
   logic [23:0]                gain_ff, gain_in;
   logic signed [31:0]         angle_lp_ff, angle_lp_in;
   logic signed [31:0]         rate_lp_ff, rate_lp_in;
   logic                       zero_ff, zero_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in;
   logic signed [CORDIC_W-1:0] y_ff, y_in;
   logic signed [Z_W-1:0]      z_ff, z_in;
   logic signed [15:0]         ang_ff, ang_in;
   logic signed [15:0]         gz_ff, gz_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]         out_ang_ff, out_ang_in;
   logic signed [23:0]         out_sm_ff, out_sm_in;
   logic signed [23:0]         out_rt_ff, out_rt_in;
   logic signed [23:0]         out_fu_ff, out_fu_in;

   logic signed [CORDIC_W-1:0] ax_sc, ay_sc, x_sh, y_sh;
   logic signed [Z_W-1:0]      tab_z, z_bias;
   logic signed [ZR_W-1:0]     z_rnd;
   logic signed [OPA_W-1:0]    op_a;
   logic signed [OPB_W-1:0]    op_b;
   logic signed [ACC_W-1:0]    prod_ext, acc_bias;
   logic signed [RND_W-1:0]    acc_rnd;
   logic signed [31:0]         acc_sat;
   logic signed [23:0]         sm_val, rt_val;

   // rounding and saturation of the accumulated filter sum
   assign acc_bias = acc_ff + (ACC_W'(1) <<< (F - 1));
   assign acc_rnd  = acc_bias[ACC_W-1:F];
   assign acc_sat  = (acc_rnd > LP_MAX) ? 32'sh7FFFFFFF :
                     (acc_rnd < LP_MIN) ? 32'sh80000000 : acc_rnd[31:0];

   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   assign x_sh  = x_ff >>> step_ff;
   assign y_sh  = y_ff >>> step_ff;
   assign tab_z = signed'({{(Z_W-21){1'b0}}, atan_q(5'(step_ff))});

   assign z_bias = z_ff + Z_W'(128);
   assign z_rnd  = z_bias[Z_W-1:8];

   assign ax_sc = {{(CORDIC_W-24){req_ch.accel_x[15]}}, req_ch.accel_x, 8'h00};
   assign ay_sc = {{(CORDIC_W-24){req_ch.accel_y[15]}}, req_ch.accel_y, 8'h00};

   assign sm_val = round8_sat24(angle_lp_ff);
   assign rt_val = round8_sat24(rate_lp_ff);

   // operand select of the shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (mcnt_ff)
         MC_MUL_A: begin
            op_a = OPA_W'(ang_ff);
            op_b = signed'({{(OPB_W-16){1'b0}}, coef_a_ff});
         end
         MC_MUL_B: begin
            op_a = angle_lp_ff;
            op_b = signed'({{(OPB_W-16){1'b0}}, coef_b_ff});
         end
         MC_MUL_G: begin
            op_a = OPA_W'(gz_ff);
            op_b = signed'({{(OPB_W-24){1'b0}}, gain_ff});
         end
         MC_MUL_R: begin
            op_a = rate_lp_ff;
            op_b = signed'({{(OPB_W-16){1'b0}}, coef_b_ff});
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      mcnt_in      = mcnt_ff;
      coef_a_in    = coef_a_ff;
      coef_b_in    = coef_b_ff;
      gain_in      = gain_ff;
      angle_lp_in  = angle_lp_ff;
      rate_lp_in   = rate_lp_ff;
      zero_in      = zero_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      ang_in       = ang_ff;
      gz_in        = gz_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      out_ang_in   = out_ang_ff;
      out_sm_in    = out_sm_ff;
      out_rt_in    = out_rt_ff;
      out_fu_in    = out_fu_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_COEF_A:    coef_a_in = csr_wdata[15:0];
            CSR_COEF_B:    coef_b_in = csr_wdata[15:0];
            CSR_GYRO_GAIN: gain_in   = csr_wdata[23:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               zero_in = (req_ch.accel_x == 16'sd0) && (req_ch.accel_y == 16'sd0);
               gz_in   = req_ch.gyro_z;
               step_in = '0;
               // left half plane: rotate by 180 degrees first
               if (req_ch.accel_x[15]) begin
                  x_in = -ax_sc;
                  y_in = -ay_sc;
                  z_in = req_ch.accel_y[15] ? -DEG180_Q : DEG180_Q;
               end else begin
                  x_in = ax_sc;
                  y_in = ay_sc;
                  z_in = '0;
               end
               state_in = ST_CORDIC;
            end
         end
         ST_CORDIC: begin
            if (!y_ff[CORDIC_W-1]) begin
               x_in = x_ff + y_sh;
               y_in = y_ff - x_sh;
               z_in = z_ff + tab_z;
            end else begin
               x_in = x_ff - y_sh;
               y_in = y_ff + x_sh;
               z_in = z_ff - tab_z;
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(N_STEPS - 1)) begin
               mcnt_in  = MC_ANGLE;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in = op_a * op_b;
            mcnt_in = mcnt_ff + 3'd1;
            case (mcnt_ff)
               MC_ANGLE: begin
                  if (zero_ff) begin
                     ang_in = '0;
                  end else if (z_rnd > ZR_MAX) begin
                     ang_in = 16'(ZR_MAX);
                  end else if (z_rnd < ZR_MIN) begin
                     ang_in = 16'(ZR_MIN);
                  end else begin
                     ang_in = z_rnd[15:0];
                  end
               end
               MC_MUL_A: ;
               MC_MUL_B: acc_in = prod_ext <<< 8;
               MC_MUL_G: acc_in = acc_ff + prod_ext;
               MC_MUL_R: begin
                  // angle sum is complete, gyro sum starts fresh
                  angle_lp_in = acc_sat;
                  acc_in      = prod_ext <<< (F - 8);
               end
               MC_ACC_R: acc_in = acc_ff + prod_ext;
               MC_STORE_R: begin
                  rate_lp_in = acc_sat;
                  state_in   = ST_DONE;
               end
               default: ;
            endcase
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_ang_in   = ang_ff;
               out_sm_in    = sm_val;
               out_rt_in    = rt_val;
               out_fu_in    = sat_sum24(sm_val, rt_val);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         mcnt_ff      <= MC_ANGLE;
         coef_a_ff    <= COEF_A_RST;
         coef_b_ff    <= COEF_B_RST;
         gain_ff      <= GYRO_GAIN_RST;
         angle_lp_ff  <= '0;
         rate_lp_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         mcnt_ff      <= mcnt_in;
         coef_a_ff    <= coef_a_in;
         coef_b_ff    <= coef_b_in;
         gain_ff      <= gain_in;
         angle_lp_ff  <= angle_lp_in;
         rate_lp_ff   <= rate_lp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      zero_ff    <= zero_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      ang_ff     <= ang_in;
      gz_ff      <= gz_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      out_ang_ff <= out_ang_in;
      out_sm_ff  <= out_sm_in;
      out_rt_ff  <= out_rt_in;
      out_fu_ff  <= out_fu_in;
   end

   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.accel_angle    = out_ang_ff;
   assign rsp_ch.smoothed_angle = out_sm_ff;
   assign rsp_ch.rate_angle     = out_rt_ff;
   assign rsp_ch.fused_angle    = out_fu_ff;

endmodule

// ===== hw/rtl/tcf_checker.sv =====
// port-level checks of the tilt complementary filter, bound to the top level
module tcf_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] accel_angle,
   input logic signed [23:0] smoothed_angle,
   input logic signed [23:0] rate_angle,
   input logic signed [23:0] fused_angle
);
   import tcf_pkg::*;

   localparam logic signed [15:0] ANG_HI = 16'(ANGLE_MAX);
   localparam logic signed [15:0] ANG_LO = -16'(ANGLE_MAX);

   // no result beat right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one sample in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("sample accepted while busy");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (accel_angle <= ANG_HI && accel_angle >= ANG_LO))
      else $error("tilt angle out of range");

   a_fused_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (fused_angle == sat_sum24(smoothed_angle, rate_angle)))
      else $error("fused angle is not the saturated sum");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(fused_angle)
                                     && $stable(accel_angle)))
      else $error("stalled result beat changed");

endmodule

bind tilt_complementary_filter_unit tcf_checker u_tcf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .accel_angle    (rsp_ch.accel_angle),
   .smoothed_angle (rsp_ch.smoothed_angle),
   .rate_angle     (rsp_ch.rate_angle),
   .fused_angle    (rsp_ch.fused_angle)
);

// ===== tb/sv/tb_top.sv =====
// self-checking bench for the tilt complementary filter unit: directed table, then random samples
`timescale 1ns / 100ps

module tb_top;
   import tcf_pkg::*;

   localparam int STEPS        = 16;
   localparam int FRAC         = 16;
   localparam int QUIET_LIMIT  = 3000;
   localparam int HOLD_AT      = 230;
   localparam int HOLD_CYCLES  = 400;
   localparam int TAIL_CYCLES  = 40;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 2'd3;

   localparam longint ACC_MAX = 64'sd2147483647;
   localparam longint ACC_MIN = -64'sd2147483648;
   localparam longint OUT_HI  = 64'sd8388607;
   localparam longint OUT_LO  = -64'sd8388608;

   // atan(2^-i) in 1/32768 degree
   localparam longint ATAN_Q [24] = '{
      1474560, 870484, 459940, 233473, 117189, 58653, 29333, 14667,
      7334, 3667, 1833, 917, 458, 229, 115, 57,
      29, 14, 7, 4, 2, 1, 0, 0
   };

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] gyro_z;
   } tilt_sample_type;

   typedef struct packed {
      logic signed [15:0] accel_angle;
      logic signed [23:0] smoothed_angle;
      logic signed [23:0] rate_angle;
      logic signed [23:0] fused_angle;
   } tilt_result_type;

   // ax, ay, gz, result known, angle, smoothed, rate, fused
   typedef struct {
      int ax;
      int ay;
      int gz;
      bit known;
      int e_ang;
      int e_sm;
      int e_rt;
      int e_fu;
   } stim_row_type;

   stim_row_type dir_rows [22] = '{
      '{0, 0, 0, 1'b1, 0, 0, 0, 0},          // zero vector right after reset
      '{0, 0, 0, 1'b1, 0, 0, 0, 0},
      '{32767, 0, 0, 1'b0, 0, 0, 0, 0},
      '{-32768, 0, 0, 1'b0, 0, 0, 0, 0},     // near +180
      '{0, 32767, 32767, 1'b0, 0, 0, 0, 0},
      '{0, -32768, -32768, 1'b0, 0, 0, 0, 0},
      '{-32768, -1, 0, 1'b0, 0, 0, 0, 0},    // near -180
      '{-32768, 1, 0, 1'b0, 0, 0, 0, 0},
      '{-1, 0, 1, 1'b0, 0, 0, 0, 0},
      '{-1, -1, -1, 1'b0, 0, 0, 0, 0},
      '{32767, 32767, 32767, 1'b0, 0, 0, 0, 0},
      '{-32768, -32768, -32768, 1'b0, 0, 0, 0, 0},
      '{-32768, 32767, 100, 1'b0, 0, 0, 0, 0},
      '{32767, -32768, -100, 1'b0, 0, 0, 0, 0},
      '{1, 1, 0, 1'b0, 0, 0, 0, 0},
      '{1, -1, 0, 1'b0, 0, 0, 0, 0},
      '{0, 1, 0, 1'b0, 0, 0, 0, 0},
      '{0, -1, 0, 1'b0, 0, 0, 0, 0},
      '{-1, 32767, 0, 1'b0, 0, 0, 0, 0},
      '{0, 0, 32767, 1'b0, 0, 0, 0, 0},
      '{0, 0, -32768, 1'b0, 0, 0, 0, 0},
      '{-21846, 21845, 12345, 1'b0, 0, 0, 0, 0}
   };

   logic clock = 1'b0;
   logic reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tcf_req_if req ();
   tcf_rsp_if rsp ();

   tilt_complementary_filter_unit #(
      .CORDIC_STEPS   (STEPS),
      .COEF_FRAC_BITS (FRAC)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req),
      .rsp_ch    (rsp),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // filter model state and registers
   logic [15:0] cfg_coef_a;
   logic [15:0] cfg_coef_b;
   logic [23:0] cfg_gain;
   longint      angle_acc;
   longint      rate_acc;

   tilt_result_type pending_tilt [$];
   bit              steady;
   int unsigned     mismatches    = 0;
   int unsigned     results_taken = 0;
   int unsigned     quiet_cycles  = 0;
   int unsigned     hold_left     = 0;
   bit              hold_done     = 1'b0;

   function automatic longint saturate(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // round to nearest, ties up
   function automatic longint round_shift(input longint v, input int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint tilt_cordic(input longint x, input longint y);
      longint z;
      longint xs;
      longint ys;
      int     i;
      z = 0;
      if (x == 0 && y == 0) begin
         return 0;
      end
      x = x * 256;
      y = y * 256;
      // left half plane: rotate by 180 first
      if (x < 0) begin
         z = (y >= 0) ? longint'(DEG180_Q) : -longint'(DEG180_Q);
         x = -x;
         y = -y;
      end
      for (i = 0; i < STEPS && i < TABLE_LEN; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ATAN_Q[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ATAN_Q[i];
         end
      end
      return saturate(round_shift(z, 8), -ANGLE_MAX, ANGLE_MAX);
   endfunction

   function automatic tilt_result_type predict_tilt(input tilt_sample_type s);
      tilt_result_type r;
      longint ang;
      longint num;
      longint sm;
      longint rt;
      longint fu;
      longint a;
      longint b;
      longint g;
      a = cfg_coef_a;
      b = cfg_coef_b;
      g = cfg_gain;
      ang = tilt_cordic(longint'(s.accel_x), longint'(s.accel_y));
      num = a * ang * 256 + b * angle_acc;
      angle_acc = saturate(round_shift(num, FRAC), ACC_MIN, ACC_MAX);
      num = g * longint'(s.gyro_z) * (longint'(1) << (FRAC - 8)) + b * rate_acc;
      rate_acc = saturate(round_shift(num, FRAC), ACC_MIN, ACC_MAX);
      sm = saturate(round_shift(angle_acc, 8), OUT_LO, OUT_HI);
      rt = saturate(round_shift(rate_acc, 8), OUT_LO, OUT_HI);
      fu = saturate(sm + rt, OUT_LO, OUT_HI);
      r.accel_angle    = ang[15:0];
      r.smoothed_angle = sm[23:0];
      r.rate_angle     = rt[23:0];
      r.fused_angle    = fu[23:0];
      return r;
   endfunction

   function automatic logic [15:0] corner_value();
      case ($urandom_range(0, 4))
         0: return 16'h8000;
         1: return 16'hFFFF;
         2: return 16'h0000;
         3: return 16'h0001;
         default: return 16'h7FFF;
      endcase
   endfunction

   function automatic tilt_sample_type random_sample(input tilt_sample_type prev);
      tilt_sample_type s;
      int unsigned     pick;
      pick = $urandom_range(0, 99);
      s.accel_x = 16'($urandom);
      s.accel_y = 16'($urandom);
      s.gyro_z  = 16'($urandom);
      if (pick < 40) begin
         // full range as drawn
      end else if (pick < 60) begin
         s.accel_x = 16'(int'($urandom_range(0, 127)) - 64);
         s.accel_y = 16'(int'($urandom_range(0, 127)) - 64);
         s.gyro_z  = 16'(int'($urandom_range(0, 127)) - 64);
      end else if (pick < 75) begin
         // slow drift around the last sample so the filters settle
         s.accel_x = 16'(int'(prev.accel_x) + int'($urandom_range(0, 16)) - 8);
         s.accel_y = 16'(int'(prev.accel_y) + int'($urandom_range(0, 16)) - 8);
         s.gyro_z  = 16'(int'(prev.gyro_z) + int'($urandom_range(0, 16)) - 8);
      end else if (pick < 85) begin
         // close to the +/-180 seam
         s.accel_x = 16'(-int'($urandom_range(1, 32768)));
         s.accel_y = 16'(int'($urandom_range(0, 4)) - 2);
      end else if (pick < 92) begin
         if ($urandom_range(0, 1) != 0) begin
            s.accel_x = '0;
         end else begin
            s.accel_y = '0;
         end
      end else if (pick < 97) begin
         s.accel_x = corner_value();
         s.accel_y = corner_value();
         s.gyro_z  = corner_value();
      end else begin
         s.accel_x = '0;
         s.accel_y = '0;
      end
      return s;
   endfunction

   // one sample beat; the expectation is queued once the beat is taken
   task automatic drive_sample(input tilt_sample_type s, input bit known,
                               input tilt_result_type fixed);
      tilt_result_type r;
      while (!steady && $urandom_range(0, 99) < 14) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.accel_x <= s.accel_x;
      req.accel_y <= s.accel_y;
      req.gyro_z  <= s.gyro_z;
      @(posedge clock);
      while (!req.ready) begin
         @(posedge clock);
      end
      r = predict_tilt(s);
      pending_tilt.push_back(known ? fixed : r);
   endtask

   task automatic run_random(input int count, input int calm_from, input int calm_to);
      tilt_sample_type s;
      int              k;
      s = '0;
      for (k = 0; k < count; k++) begin
         steady <= (k >= calm_from && k < calm_to);
         s = random_sample(s);
         drive_sample(s, 1'b0, '0);
      end
      steady <= 1'b0;
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (pending_tilt.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic csr_beat(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_COEF_A:    cfg_coef_a = data[15:0];
         CSR_COEF_B:    cfg_coef_b = data[15:0];
         CSR_GYRO_GAIN: cfg_gain   = data;
         default: ;
      endcase
   endtask

   // every batch also hits the unused index, which must change nothing
   task automatic program_filter(input logic [23:0] a, input logic [23:0] b,
                                 input logic [23:0] g);
      csr_beat(CSR_COEF_A, a);
      csr_beat(CSR_COEF_B, b);
      csr_beat(CSR_GYRO_GAIN, g);
      csr_beat(CSR_UNUSED_IDX, 24'($urandom));
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   task automatic take_result();
      tilt_result_type want;
      results_taken++;
      if (pending_tilt.size() == 0) begin
         mismatches++;
         $display("%0t: result beat with no sample pending, expected none, actual %0d",
                  $time, rsp.accel_angle);
      end else begin
         want = pending_tilt.pop_front();
         check_field("accel_angle", want.accel_angle, rsp.accel_angle);
         check_field("smoothed_angle", want.smoothed_angle, rsp.smoothed_angle);
         check_field("rate_angle", want.rate_angle, rsp.rate_angle);
         check_field("fused_angle", want.fused_angle, rsp.fused_angle);
      end
   endtask

   // result side, with one long hold-off to back the unit up
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            take_result();
         end
         if (results_taken == HOLD_AT && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= steady || ($urandom_range(0, 99) >= 14);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      tilt_sample_type s;
      tilt_result_type fixed;
      int              k;
      reset       <= 1'b1;
      req.valid   <= 1'b0;
      req.accel_x <= '0;
      req.accel_y <= '0;
      req.gyro_z  <= '0;
      csr_wr_en   <= 1'b0;
      csr_index   <= '0;
      csr_wdata   <= '0;
      steady      <= 1'b0;
      cfg_coef_a = COEF_A_RST;
      cfg_coef_b = COEF_B_RST;
      cfg_gain   = GYRO_GAIN_RST;
      angle_acc  = 0;
      rate_acc   = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < $size(dir_rows); k++) begin
         s.accel_x = 16'(dir_rows[k].ax);
         s.accel_y = 16'(dir_rows[k].ay);
         s.gyro_z  = 16'(dir_rows[k].gz);
         fixed.accel_angle    = 16'(dir_rows[k].e_ang);
         fixed.smoothed_angle = 24'(dir_rows[k].e_sm);
         fixed.rate_angle     = 24'(dir_rows[k].e_rt);
         fixed.fused_angle    = 24'(dir_rows[k].e_fu);
         drive_sample(s, dir_rows[k].known, fixed);
      end
      run_random(260, 40, 140);
      wait_drained();

      // filters switched off
      program_filter(24'd0, 24'd0, 24'd0);
      run_random(50, 0, 0);
      wait_drained();

      // weights summing near two: states run into the rails
      program_filter(24'd65535, 24'd65535, 24'hFFFFFF);
      run_random(90, 0, 0);
      wait_drained();

      k = $urandom_range(1, 8000);
      program_filter(24'(k), 24'(65536 - k), 24'($urandom_range(0, 100000)));
      run_random(80, 0, 0);
      wait_drained();

      // bits above the register width must be dropped
      program_filter(24'($urandom), 24'($urandom), 24'($urandom));
      run_random(80, 0, 0);
      wait_drained();

      program_filter(24'd1, 24'd0, 24'd1);
      run_random(30, 0, 0);
      wait_drained();

      program_filter({8'hAB, COEF_A_RST}, {8'h5A, COEF_B_RST}, GYRO_GAIN_RST);
      run_random(60, 0, 0);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_tilt.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
